>>> rtl/core/sihm_pkg.sv
// Shared types and codes for the interrupt hook-id mask manager.
`timescale 1ns / 1ps
package sihm_pkg;

  localparam int CMD_W    = 3;
  localparam int LINE_W   = 6;
  localparam int ID_W     = 5;
  localparam int DONE_W   = 32;
  localparam int STATUS_W = 2;
  localparam int ACT_W    = 2;

  localparam logic [CMD_W-1:0] CMD_REGISTER = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_HANDLE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ENABLE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DISABLE  = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_LINE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_FREE  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_SPURIOUS = 2'd3;

  localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MASK   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_UNMASK = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]     assigned_id;
    logic [STATUS_W-1:0] status;
    logic [ACT_W-1:0]    mask_action;
    logic                line_masked;
    logic                was_enabled;
  } result_t;

endpackage

>>> rtl/core/sihm_lane.sv
// One hook-id lane: next registered and active bit for a single id.
`timescale 1ns / 1ps
module sihm_lane (
  input  logic [sihm_pkg::CMD_W-1:0] cmd,
  input  logic                       reg_bit,
  input  logic                       act_bit,
  input  logic                       sel,
  input  logic                       pick,
  input  logic                       done,
  output logic                       reg_out,
  output logic                       act_out
);
  import sihm_pkg::*;

  always_comb begin
    reg_out = reg_bit;
    act_out = act_bit;
    case (cmd)
      CMD_REGISTER: begin
        reg_out = reg_bit | pick;
        act_out = act_bit & ~pick;
      end
      CMD_REMOVE: begin
        reg_out = reg_bit & ~sel;
        act_out = act_bit & ~sel;
      end
      CMD_HANDLE: begin
        // set busy if registered, then drop those whose handler finished
        act_out = (act_bit | reg_bit) & ~(done & reg_bit);
      end
      CMD_ENABLE: begin
        act_out = act_bit & ~sel;
      end
      CMD_DISABLE: begin
        act_out = act_bit | sel;
      end
      default: begin
        reg_out = reg_bit;
        act_out = act_bit;
      end
    endcase
  end

endmodule

>>> rtl/core/sihm_merge.sv
// Merge stage: combines lane bitmaps into status, mask action and mask state.
`timescale 1ns / 1ps
module sihm_merge #(
  parameter int MAX_HOOKS = 32
) (
  input  logic [sihm_pkg::CMD_W-1:0] cmd,
  input  logic [MAX_HOOKS-1:0]       reg_old,
  input  logic [MAX_HOOKS-1:0]       act_old,
  input  logic [MAX_HOOKS-1:0]       reg_new,
  input  logic [MAX_HOOKS-1:0]       act_new,
  input  logic [MAX_HOOKS-1:0]       sel,
  input  logic [MAX_HOOKS-1:0]       pick,
  input  logic                       masked_old,
  output sihm_pkg::result_t          res,
  output logic                       masked_new
);
  import sihm_pkg::*;

  localparam int IDX_W = (MAX_HOOKS > 1) ? $clog2(MAX_HOOKS) : 1;

  logic             free_any;
  logic             reg_new_zero;
  logic             act_new_zero;
  logic [IDX_W-1:0] pick_idx;

  assign free_any     = |(~reg_old);
  assign reg_new_zero = (reg_new == '0);
  assign act_new_zero = (act_new == '0);

  // one-hot to index: independent OR of each lane's position
  always_comb begin
    pick_idx = '0;
    for (int k = 0; k < MAX_HOOKS; k++) begin
      if (pick[k]) begin
        pick_idx = pick_idx | IDX_W'(k);
      end
    end
  end

  always_comb begin
    res             = '0;
    res.status      = STAT_OK;
    res.mask_action = ACT_NONE;
    case (cmd)
      CMD_REGISTER: begin
        if (!free_any) begin
          res.status = STAT_NO_FREE;
        end else begin
          res.assigned_id = ID_W'(pick_idx);
          if (act_new_zero) begin
            res.mask_action = ACT_UNMASK;
          end
        end
      end
      CMD_REMOVE: begin
        if (reg_new_zero) begin
          res.mask_action = ACT_MASK;
        end else if (act_new_zero) begin
          res.mask_action = ACT_UNMASK;
        end
      end
      CMD_HANDLE: begin
        if (reg_old == '0) begin
          res.status      = STAT_SPURIOUS;
          res.mask_action = ACT_MASK;
        end else if (act_new_zero) begin
          res.mask_action = ACT_UNMASK;
        end else begin
          res.mask_action = ACT_MASK;
        end
      end
      CMD_ENABLE: begin
        if (act_new_zero) begin
          res.mask_action = ACT_UNMASK;
        end
      end
      CMD_DISABLE: begin
        if ((act_old & sel) == '0) begin
          res.mask_action = ACT_MASK;
          res.was_enabled = 1'b1;
        end
      end
      default: begin
        res.mask_action = ACT_NONE;
      end
    endcase

    case (res.mask_action)
      ACT_MASK:   masked_new = 1'b1;
      ACT_UNMASK: masked_new = 1'b0;
      default:    masked_new = masked_old;
    endcase
    res.line_masked = masked_new;
  end

endmodule

>>> rtl/core/shared_irq_hook_mask_manager.sv
// Top level: per-line hook-id bitmap store, id lanes, merge and result register.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake               Beat contents
//  --------  ---------  ----------------------  --------------------------------------
//  command   in         start && !busy          cmd, line, hook_id, handler_done
//  result    out        result_valid (1 cycle)  assigned_id, status, mask_action,
//                                               line_masked, was_enabled
//
//  Each command is accepted in ST_IDLE and executed in ST_EXEC: the accept edge reads
//  the line's entry from the line store, and the next edge writes the updated entry
//  back and registers the result. Busy stays high meanwhile, so a new command is not
//  accepted until the previous one has been written back; the registered read of the
//  line store, with no forwarding of the write-back, requires this. After rst the
//  block sweeps the line store, one line per cycle, with busy high. The result beat
//  is shown for exactly one cycle and cannot be held off by the receiver.
//
module shared_irq_hook_mask_manager #(
  parameter int NUM_LINES = 64,
  parameter int MAX_HOOKS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [sihm_pkg::CMD_W-1:0]    cmd,
  input  logic [sihm_pkg::LINE_W-1:0]   line,
  input  logic [sihm_pkg::ID_W-1:0]     hook_id,
  input  logic [sihm_pkg::DONE_W-1:0]   handler_done,
  output logic                          result_valid,
  output logic [sihm_pkg::ID_W-1:0]     assigned_id,
  output logic [sihm_pkg::STATUS_W-1:0] status,
  output logic [sihm_pkg::ACT_W-1:0]    mask_action,
  output logic                          line_masked,
  output logic                          was_enabled
);
  import sihm_pkg::*;

  localparam int IDX_W  = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int ENT_W  = 2 * MAX_HOOKS + 1;
  localparam int CMP_W  = 11;
  localparam int HCMP_W = 7;
  localparam logic [CMP_W-1:0] NUM_LINES_C = CMP_W'(NUM_LINES);
  localparam logic [IDX_W-1:0] LAST_LINE   = IDX_W'(NUM_LINES - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  // Control state
  logic [1:0]       state;
  logic [IDX_W-1:0] clr_idx;
  logic             accept;

  // Captured command beat
  logic [CMD_W-1:0]     cmd_q;
  logic [IDX_W-1:0]     line_q;
  logic                 bad_line_q;
  logic [ID_W-1:0]      hook_id_q;
  logic [DONE_W-1:0]    done_q;

  // Line store: {masked, active ids, registered ids}
  logic [ENT_W-1:0] mem [NUM_LINES];
  logic [ENT_W-1:0] rd_entry;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;

  logic [MAX_HOOKS-1:0] reg_old;
  logic [MAX_HOOKS-1:0] act_old;
  logic                 masked_old;
  logic [MAX_HOOKS-1:0] reg_new;
  logic [MAX_HOOKS-1:0] act_new;
  logic [MAX_HOOKS-1:0] sel;
  logic [MAX_HOOKS-1:0] done_vec;
  logic [MAX_HOOKS-1:0] free_ids;
  logic [MAX_HOOKS-1:0] pick;
  logic                 masked_new;
  result_t              merged;
  result_t              res_final;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Sequencer: sweep the store after reset, then alternate accept and execute.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_idx      <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_EXEC);
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_LINE) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the command beat for the execute cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= cmd;
      line_q     <= IDX_W'(line);
      bad_line_q <= (CMP_W'(line) >= NUM_LINES_C);
      hook_id_q  <= hook_id;
      done_q     <= handler_done;
    end
  end

  // Write back the updated entry, or the reset value during the sweep.
  assign mem_we    = (state == ST_CLEAR) || ((state == ST_EXEC) && !bad_line_q);
  assign mem_waddr = (state == ST_CLEAR) ? clr_idx : line_q;
  assign mem_wdata = (state == ST_CLEAR) ? {1'b1, {(2 * MAX_HOOKS){1'b0}}}
                                         : {masked_new, act_new, reg_new};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_entry <= mem[IDX_W'(line)];
    end
  end

  assign reg_old    = rd_entry[MAX_HOOKS-1:0];
  assign act_old    = rd_entry[2*MAX_HOOKS-1:MAX_HOOKS];
  assign masked_old = rd_entry[ENT_W-1];

  // Lowest free id as a one-hot vector.
  assign free_ids = ~reg_old;
  assign pick     = free_ids & (~free_ids + 1'b1);

  // One lane per hook id.
  for (genvar k = 0; k < MAX_HOOKS; k++) begin : g_lane
    assign sel[k] = (HCMP_W'(hook_id_q) == HCMP_W'(k));
    if (k < DONE_W) begin : g_done
      assign done_vec[k] = done_q[k];
    end else begin : g_nodone
      assign done_vec[k] = 1'b0;
    end

    sihm_lane u_lane (
      .cmd     (cmd_q),
      .reg_bit (reg_old[k]),
      .act_bit (act_old[k]),
      .sel     (sel[k]),
      .pick    (pick[k]),
      .done    (done_vec[k]),
      .reg_out (reg_new[k]),
      .act_out (act_new[k])
    );
  end

  sihm_merge #(
    .MAX_HOOKS (MAX_HOOKS)
  ) u_merge (
    .cmd        (cmd_q),
    .reg_old    (reg_old),
    .act_old    (act_old),
    .reg_new    (reg_new),
    .act_new    (act_new),
    .sel        (sel),
    .pick       (pick),
    .masked_old (masked_old),
    .res        (merged),
    .masked_new (masked_new)
  );

  // An out-of-range line reports masked and touches nothing.
  always_comb begin
    res_final = merged;
    if (bad_line_q) begin
      res_final             = '0;
      res_final.status      = STAT_BAD_LINE;
      res_final.mask_action = ACT_NONE;
      res_final.line_masked = 1'b1;
    end
  end

  // Result register: one beat, one cycle.
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      assigned_id <= res_final.assigned_id;
      status      <= res_final.status;
      mask_action <= res_final.mask_action;
      line_masked <= res_final.line_masked;
      was_enabled <= res_final.was_enabled;
    end
  end

`ifndef SYNTH
  // Every accepted command yields a result once its execute state has passed.
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 result_valid)
    else $error("accepted command produced no result");

  // Results never come in two adjacent cycles.
  a_no_double: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for two cycles");

  // Reported mask state follows the reported action.
  a_mask_follows: assert property (@(posedge clk) disable iff (rst)
    (result_valid && mask_action == ACT_MASK) |-> line_masked)
    else $error("mask action without masked line");

  a_unmask_follows: assert property (@(posedge clk) disable iff (rst)
    (result_valid && mask_action == ACT_UNMASK) |-> !line_masked)
    else $error("unmask action with masked line");
`endif

endmodule

>>> verif/irq_hook_checker.sv
// Checker: tracks per-line hook state, predicts each command's result and compares beats.
`timescale 1ns / 1ps
module irq_hook_checker #(
  parameter int NUM_LINES = 64,
  parameter int MAX_HOOKS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [sihm_pkg::CMD_W-1:0]    cmd,
  input  logic [sihm_pkg::LINE_W-1:0]   line,
  input  logic [sihm_pkg::ID_W-1:0]     hook_id,
  input  logic [sihm_pkg::DONE_W-1:0]   handler_done,
  input  logic                          result_valid,
  input  logic [sihm_pkg::ID_W-1:0]     assigned_id,
  input  logic [sihm_pkg::STATUS_W-1:0] status,
  input  logic [sihm_pkg::ACT_W-1:0]    mask_action,
  input  logic                          line_masked,
  input  logic                          was_enabled,
  output int unsigned                   open_results,
  output int unsigned                   mismatches
);

  import sihm_pkg::*;

  localparam logic [DONE_W-1:0] HOOK_SPACE = (MAX_HOOKS >= DONE_W) ? {DONE_W{1'b1}} :
                                             DONE_W'((64'd1 << MAX_HOOKS) - 64'd1);

  logic [DONE_W-1:0] hooks_registered [NUM_LINES];
  logic [DONE_W-1:0] hooks_active     [NUM_LINES];
  logic              line_is_masked   [NUM_LINES];
  result_t           cmd_results_due  [$];
  int unsigned       n_bad = 0;

  assign mismatches = n_bad;

  task automatic note_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $time, what);
    n_bad++;
  endtask

  // Apply one command to the tracked line state and return its result.
  function automatic result_t run_hook_cmd(input logic [CMD_W-1:0]  c,
                                           input logic [LINE_W-1:0] ln,
                                           input logic [ID_W-1:0]   id,
                                           input logic [DONE_W-1:0] done);
    result_t           r;
    logic [DONE_W-1:0] sel;
    logic [DONE_W-1:0] free;
    int                k;
    r = '0;
    r.status      = STAT_OK;
    r.mask_action = ACT_NONE;
    if (int'(ln) >= NUM_LINES) begin
      r.status      = STAT_BAD_LINE;
      r.line_masked = 1'b1;
      return r;
    end
    sel = (int'(id) < MAX_HOOKS) ? (DONE_W'(1) << id) : '0;
    case (c)
      CMD_REGISTER: begin
        free = ~hooks_registered[ln] & HOOK_SPACE;
        if (free == '0) begin
          r.status = STAT_NO_FREE;
        end else begin
          // lowest free id wins
          for (k = DONE_W - 1; k >= 0; k--)
            if (free[k]) r.assigned_id = ID_W'(k);
          sel = DONE_W'(1) << r.assigned_id;
          hooks_registered[ln] |= sel;
          hooks_active[ln]     &= ~sel;
          if (hooks_active[ln] == '0) begin
            line_is_masked[ln] = 1'b0;
            r.mask_action      = ACT_UNMASK;
          end
        end
      end
      CMD_REMOVE: begin
        hooks_registered[ln] &= ~sel;
        hooks_active[ln]     &= ~sel;
        if (hooks_registered[ln] == '0) begin
          line_is_masked[ln] = 1'b1;
          r.mask_action      = ACT_MASK;
        end else if (hooks_active[ln] == '0) begin
          line_is_masked[ln] = 1'b0;
          r.mask_action      = ACT_UNMASK;
        end
      end
      CMD_HANDLE: begin
        line_is_masked[ln] = 1'b1;
        r.mask_action      = ACT_MASK;
        if (hooks_registered[ln] == '0) begin
          r.status = STAT_SPURIOUS;
        end else begin
          hooks_active[ln] |= hooks_registered[ln];
          hooks_active[ln] &= ~(done & hooks_registered[ln]);
          if (hooks_active[ln] == '0) begin
            line_is_masked[ln] = 1'b0;
            r.mask_action      = ACT_UNMASK;
          end
        end
      end
      CMD_ENABLE: begin
        hooks_active[ln] &= ~sel;
        if (hooks_active[ln] == '0) begin
          line_is_masked[ln] = 1'b0;
          r.mask_action      = ACT_UNMASK;
        end
      end
      CMD_DISABLE: begin
        if ((hooks_active[ln] & sel) == '0) begin
          hooks_active[ln]  |= sel;
          line_is_masked[ln] = 1'b1;
          r.mask_action      = ACT_MASK;
          r.was_enabled      = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.line_masked = line_is_masked[ln];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    int      i;
    if (rst) begin
      for (i = 0; i < NUM_LINES; i++) begin
        hooks_registered[i] = '0;
        hooks_active[i]     = '0;
        line_is_masked[i]   = 1'b1;
      end
      cmd_results_due.delete();
    end else begin
      // compare first: a beat on this edge always belongs to an earlier command
      if (result_valid) begin
        if (cmd_results_due.size() == 0) begin
          note_mismatch("result beat with no command waiting");
        end else begin
          want = cmd_results_due.pop_front();
          if (assigned_id !== want.assigned_id)
            note_mismatch($sformatf("assigned_id %0d, predicted %0d",
                                    assigned_id, want.assigned_id));
          if (status !== want.status)
            note_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
          if (mask_action !== want.mask_action)
            note_mismatch($sformatf("mask_action %0d, predicted %0d",
                                    mask_action, want.mask_action));
          if (line_masked !== want.line_masked)
            note_mismatch($sformatf("line_masked %0b, predicted %0b",
                                    line_masked, want.line_masked));
          if (was_enabled !== want.was_enabled)
            note_mismatch($sformatf("was_enabled %0b, predicted %0b",
                                    was_enabled, want.was_enabled));
        end
      end
      if (start && !busy)
        cmd_results_due.push_back(run_hook_cmd(cmd, line, hook_id, handler_done));
    end
    open_results <= cmd_results_due.size();
  end

endmodule

>>> verif/tb.sv
// Testbench top: drives hook-mask commands into the block and gives the verdict.
`timescale 1ns / 1ps
module tb;

  import sihm_pkg::*;

  localparam int NUM_LINES   = 64;
  localparam int MAX_HOOKS   = 32;
  localparam int N_ITEMS     = 1900;
  // cycles with no beat on either channel before giving up; covers the
  // post-reset line sweep plus the longest sender gap many times over
  localparam int STALL_LIMIT = 2000;

  // command codes the block does not define
  localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_C = 3'd7;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                start        = 1'b0;
  logic [CMD_W-1:0]    cmd          = '0;
  logic [LINE_W-1:0]   line         = '0;
  logic [ID_W-1:0]     hook_id      = '0;
  logic [DONE_W-1:0]   handler_done = '0;
  logic                busy;
  logic                result_valid;
  logic [ID_W-1:0]     assigned_id;
  logic [STATUS_W-1:0] status;
  logic [ACT_W-1:0]    mask_action;
  logic                line_masked;
  logic                was_enabled;

  int unsigned open_results;
  int unsigned mismatches;
  int unsigned sent        = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle     = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  shared_irq_hook_mask_manager #(
    .NUM_LINES (NUM_LINES),
    .MAX_HOOKS (MAX_HOOKS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .line         (line),
    .hook_id      (hook_id),
    .handler_done (handler_done),
    .result_valid (result_valid),
    .assigned_id  (assigned_id),
    .status       (status),
    .mask_action  (mask_action),
    .line_masked  (line_masked),
    .was_enabled  (was_enabled)
  );

  // The checker sees both channels, predicts and compares; the top makes
  // stimulus, runs a stall watchdog and reads back the open and mismatch counts.
  irq_hook_checker #(
    .NUM_LINES (NUM_LINES),
    .MAX_HOOKS (MAX_HOOKS)
  ) i_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .line         (line),
    .hook_id      (hook_id),
    .handler_done (handler_done),
    .result_valid (result_valid),
    .assigned_id  (assigned_id),
    .status       (status),
    .mask_action  (mask_action),
    .line_masked  (line_masked),
    .was_enabled  (was_enabled),
    .open_results (open_results),
    .mismatches   (mismatches)
  );

  // Watchdog: count cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("shared_irq_hook_mask_manager verification failed");
      $finish;
    end
  end

  // Sender idle time after a beat: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Handler results: empty, full, one-hot or fully random.
  function automatic logic [DONE_W-1:0] pick_done();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return DONE_W'(1) << $urandom_range(0, DONE_W - 1);
      default: return DONE_W'($urandom);
    endcase
  endfunction

  // Commands that work on a live line; leave out remove and register while filling.
  function automatic logic [CMD_W-1:0] pick_hook_op(input bit with_remove);
    case ($urandom_range(0, with_remove ? 4 : 2))
      0:       return CMD_HANDLE;
      1:       return CMD_ENABLE;
      2:       return CMD_DISABLE;
      3:       return CMD_REMOVE;
      default: return CMD_REGISTER;
    endcase
  endfunction

  // Present one command beat, hold it until accepted, then idle a while.
  // With no gap, start stays high and the next call reloads the fields.
  task automatic send_cmd(input logic [CMD_W-1:0]  c,
                          input logic [LINE_W-1:0] ln,
                          input logic [ID_W-1:0]   id,
                          input logic [DONE_W-1:0] done);
    int unsigned gap;
    gap = pick_gap();
    cmd          <= c;
    line         <= ln;
    hook_id      <= id;
    handler_done <= done;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and hold off until every predicted result has come back.
  task automatic wait_all_results();
    start <= 1'b0;
    do @(posedge clk); while (open_results != 0);
  endtask

  initial begin : stimulus
    int unsigned       n;
    int unsigned       k;
    logic [LINE_W-1:0] ln;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty line, disable/enable without hooks, register and
    // handle with full, empty and partial done maps, removes down to an
    // empty line, unknown commands, and the top line and id.
    send_cmd(CMD_HANDLE,   6'd0,  5'd0,  '0);            // spurious interrupt
    send_cmd(CMD_DISABLE,  6'd0,  5'd31, '0);            // disable unused id
    send_cmd(CMD_DISABLE,  6'd0,  5'd31, '0);            // already disabled
    send_cmd(CMD_ENABLE,   6'd0,  5'd31, '0);            // nothing active: unmask
    send_cmd(CMD_REGISTER, 6'd0,  5'd0,  '0);
    send_cmd(CMD_REGISTER, 6'd0,  5'd0,  '0);
    send_cmd(CMD_HANDLE,   6'd0,  5'd0,  '1);            // every handler done
    send_cmd(CMD_HANDLE,   6'd0,  5'd0,  '0);            // none done: line masked
    send_cmd(CMD_HANDLE,   6'd0,  5'd0,  32'h0000_0002); // partial
    send_cmd(CMD_ENABLE,   6'd0,  5'd0,  '0);
    send_cmd(CMD_DISABLE,  6'd0,  5'd1,  '0);
    send_cmd(CMD_REMOVE,   6'd0,  5'd0,  '0);            // others still active
    send_cmd(CMD_REMOVE,   6'd0,  5'd7,  '0);            // id never registered
    send_cmd(CMD_REGISTER, 6'd0,  5'd0,  '0);            // reuse freed id
    send_cmd(CMD_REMOVE,   6'd0,  5'd1,  '0);
    send_cmd(CMD_REMOVE,   6'd0,  5'd0,  '0);            // line now empty
    send_cmd(CMD_REMOVE,   6'd0,  5'd0,  '0);            // remove on empty line
    send_cmd(CMD_RSVD_A,   6'd63, 5'd0,  '0);
    send_cmd(CMD_RSVD_B,   6'd63, 5'd31, '1);
    send_cmd(CMD_RSVD_C,   6'd0,  5'd31, '1);
    send_cmd(CMD_REGISTER, 6'd63, 5'd31, '1);
    send_cmd(CMD_HANDLE,   6'd63, 5'd31, 32'hAAAA_AAAA);
    send_cmd(CMD_HANDLE,   6'd63, 5'd31, 32'h5555_5555);
    send_cmd(CMD_ENABLE,   6'd63, 5'd31, '1);

    // pause the sender until the directed part has fully drained
    wait_all_results();

    // Random episodes: fills of one line up to and past the id limit, short
    // register/handle/disable/remove lifecycles on one line, and plain noise.
    while (sent < N_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      ln      = LINE_W'($urandom);
      case ($urandom_range(0, 9))
        0, 1: begin
          n = MAX_HOOKS + $urandom_range(1, 4);
          for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) != 0)
              send_cmd(CMD_REGISTER, ln, ID_W'($urandom), pick_done());
            else
              send_cmd(pick_hook_op(1'b0), ln, ID_W'($urandom), pick_done());
          end
          // sometimes tear the line down to empty again
          if ($urandom_range(0, 1) == 0)
            for (k = 0; k < MAX_HOOKS; k++)
              send_cmd(CMD_REMOVE, ln, ID_W'(k), pick_done());
        end
        2, 3, 4, 5, 6: begin
          n = $urandom_range(1, 6);
          for (k = 0; k < n; k++)
            send_cmd(CMD_REGISTER, ln, ID_W'($urandom), pick_done());
          n = $urandom_range(4, 16);
          for (k = 0; k < n; k++)
            send_cmd(pick_hook_op(1'b1), ln, ID_W'($urandom_range(0, 7)), pick_done());
        end
        default: begin
          n = $urandom_range(1, 20);
          for (k = 0; k < n; k++)
            send_cmd(CMD_W'($urandom), LINE_W'($urandom), ID_W'($urandom),
                     DONE_W'($urandom));
        end
      endcase
      if ($urandom_range(0, 9) == 0) wait_all_results();
    end

    // drain, then idle so that any stray beat still shows
    no_idle = 1'b0;
    wait_all_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("shared_irq_hook_mask_manager verification clean");
    end else begin
      $display("shared_irq_hook_mask_manager verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/sihm_pkg.sv
rtl/core/sihm_lane.sv
rtl/core/sihm_merge.sv
rtl/core/shared_irq_hook_mask_manager.sv
verif/irq_hook_checker.sv
verif/tb.sv
